// ===== rtl/three_rotor_reflector_cipher_assert.svh =====
// Assertion macros shared by the cipher RTL.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef THREE_ROTOR_REFLECTOR_CIPHER_ASSERT_SVH
`define THREE_ROTOR_REFLECTOR_CIPHER_ASSERT_SVH

// Condition that must hold in the same cycle.
`define TRRC_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define TRRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trrc_pkg.sv =====
`timescale 1ns / 1ps

package trrc_pkg;

    localparam int LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [1:0] cfg_index_t;

    typedef struct packed {
        letter_t first;
        letter_t second;
        letter_t third;
    } pos_set_t;

    // Configuration register indexes
    localparam cfg_index_t CFG_FIRST_START  = 2'd0;
    localparam cfg_index_t CFG_SECOND_START = 2'd1;
    localparam cfg_index_t CFG_THIRD_START  = 2'd2;

    // Forward rotor wirings
    localparam letter_t ROTOR_A [LETTERS] = '{
        5'd8, 5'd17, 5'd2, 5'd11, 5'd7, 5'd5, 5'd15, 5'd9, 5'd10, 5'd19, 5'd12, 5'd13, 5'd1,
        5'd4, 5'd16, 5'd21, 5'd24, 5'd3, 5'd6, 5'd22, 5'd18, 5'd0, 5'd20, 5'd14, 5'd25, 5'd23};
    localparam letter_t ROTOR_B [LETTERS] = '{
        5'd22, 5'd0, 5'd18, 5'd20, 5'd7, 5'd4, 5'd15, 5'd12, 5'd21, 5'd6, 5'd5, 5'd13, 5'd9,
        5'd2, 5'd17, 5'd10, 5'd8, 5'd3, 5'd24, 5'd23, 5'd19, 5'd25, 5'd1, 5'd16, 5'd11, 5'd14};
    localparam letter_t ROTOR_C [LETTERS] = '{
        5'd5, 5'd17, 5'd0, 5'd9, 5'd18, 5'd6, 5'd23, 5'd24, 5'd22, 5'd20, 5'd1, 5'd12, 5'd2,
        5'd21, 5'd4, 5'd15, 5'd13, 5'd7, 5'd10, 5'd11, 5'd3, 5'd16, 5'd8, 5'd14, 5'd19, 5'd25};

    // Inverse wirings for the return path
    localparam letter_t ROTOR_A_INV [LETTERS] = '{
        5'd21, 5'd12, 5'd2, 5'd17, 5'd13, 5'd5, 5'd18, 5'd4, 5'd0, 5'd7, 5'd8, 5'd3, 5'd10,
        5'd11, 5'd23, 5'd6, 5'd14, 5'd1, 5'd20, 5'd9, 5'd22, 5'd15, 5'd19, 5'd25, 5'd16, 5'd24};
    localparam letter_t ROTOR_B_INV [LETTERS] = '{
        5'd1, 5'd22, 5'd13, 5'd17, 5'd5, 5'd10, 5'd9, 5'd4, 5'd16, 5'd12, 5'd15, 5'd24, 5'd7,
        5'd11, 5'd25, 5'd6, 5'd23, 5'd14, 5'd2, 5'd20, 5'd3, 5'd8, 5'd0, 5'd19, 5'd18, 5'd21};
    localparam letter_t ROTOR_C_INV [LETTERS] = '{
        5'd2, 5'd10, 5'd12, 5'd20, 5'd14, 5'd0, 5'd5, 5'd17, 5'd22, 5'd3, 5'd18, 5'd19, 5'd11,
        5'd16, 5'd23, 5'd15, 5'd21, 5'd1, 5'd4, 5'd24, 5'd9, 5'd13, 5'd8, 5'd6, 5'd7, 5'd25};

    localparam letter_t REFLECTOR [LETTERS] = '{
        5'd18, 5'd12, 5'd7, 5'd6, 5'd13, 5'd20, 5'd3, 5'd2, 5'd25, 5'd17, 5'd24, 5'd14, 5'd1,
        5'd4, 5'd11, 5'd23, 5'd22, 5'd9, 5'd0, 5'd21, 5'd5, 5'd19, 5'd16, 5'd15, 5'd10, 5'd8};

    // Fold a 5-bit code into 0..25
    function automatic letter_t wrap_letter(input letter_t v);
        return (v >= 5'(LETTERS)) ? letter_t'(v - 5'(LETTERS)) : v;
    endfunction

    // (v - p) mod 26, both operands already in range
    function automatic letter_t sub_mod(input letter_t v, input letter_t p);
        logic [5:0] diff;
        diff = {1'b0, v} + 6'(LETTERS) - {1'b0, p};
        return (v >= p) ? letter_t'(v - p) : diff[4:0];
    endfunction

    // (v + p) mod 26, both operands already in range
    function automatic letter_t add_mod(input letter_t v, input letter_t p);
        logic [5:0] sum;
        sum = {1'b0, v} + {1'b0, p};
        return (sum >= 6'(LETTERS)) ? letter_t'(sum - 6'(LETTERS)) : sum[4:0];
    endfunction

    function automatic letter_t step_pos(input letter_t p);
        return (p >= 5'(LETTERS - 1)) ? '0 : letter_t'(p + 5'd1);
    endfunction

endpackage

// ===== rtl/three_rotor_reflector_cipher.sv =====
// Each letter is registered in stage 1 with its rotor positions, then its result in the output stage.
// Throughput: one letter per cycle while out_ready stays high; the whole rotor pass is combinational table logic.
// Reset: rotor positions and start registers return to A, both pipeline stages empty.
// A full output stage that is not being emptied back-pressures the input only when stage 1 is full too.
`timescale 1ns / 1ps
`include "three_rotor_reflector_cipher_assert.svh"

module three_rotor_reflector_cipher (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  trrc_pkg::cfg_index_t  cfg_index,
    input  trrc_pkg::letter_t     cfg_data,
    // letter input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  trrc_pkg::letter_t     letter_in,
    input  logic                  begin_message,
    // letter output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output trrc_pkg::letter_t     letter_out
);
    import trrc_pkg::*;

    pos_set_t start_pos;
    pos_set_t cur_pos;
    letter_t  scr_result;
    logic     in_xfer;
    logic     s1_go;

    // stage 1: accepted letter with the rotor positions it is ciphered under
    logic     s1_valid_reg;
    logic     s1_valid_next;
    letter_t  s1_letter_reg;
    pos_set_t s1_pos_reg;

    // stage 2: result waiting for its transfer
    logic     out_valid_reg;
    logic     out_valid_next;
    letter_t  out_letter_reg;

    // range checks for the assertions
    logic     out_letter_ok;
    logic     s1_pos_ok;

    trrc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_pos (start_pos)
    );

    // Positions step on every input transfer, reloading first on a message start
    trrc_pos u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_xfer),
        .reload    (begin_message),
        .start_pos (start_pos),
        .cur_pos   (cur_pos)
    );

    trrc_scramble u_scramble (
        .letter (s1_letter_reg),
        .pos    (s1_pos_reg),
        .result (scr_result)
    );

    // Stage 1 moves on whenever the output register is free or being emptied
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_letter_reg <= letter_in;
            s1_pos_reg    <= cur_pos;
        end
        if (s1_go)
        begin
            out_letter_reg <= scr_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign letter_out = out_letter_reg;

    assign out_letter_ok = (out_letter_reg < 5'(LETTERS));
    assign s1_pos_ok     = (s1_pos_reg.first < 5'(LETTERS)) && (s1_pos_reg.second < 5'(LETTERS))
                           && (s1_pos_reg.third < 5'(LETTERS));

    `TRRC_ASSERT_NOW(a_out_in_range, !out_valid_reg || out_letter_ok, "result letter out of range")
    `TRRC_ASSERT_NEXT(a_s1_to_out, s1_go, out_valid_reg, "stage 1 moved but no result")
    `TRRC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_go, s1_valid_reg, "stalled letter dropped")
    `TRRC_ASSERT_NOW(a_pos_in_range, !s1_valid_reg || s1_pos_ok, "rotor position out of range")

endmodule

// ===== rtl/trrc_cfg.sv =====
`timescale 1ns / 1ps

module trrc_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  trrc_pkg::cfg_index_t  cfg_index,
    input  trrc_pkg::letter_t     cfg_data,
    output trrc_pkg::pos_set_t    start_pos
);
    import trrc_pkg::*;

    pos_set_t start_reg;
    pos_set_t start_next;

    // Unknown indexes leave the registers untouched
    always_comb
    begin
        start_next = start_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_START:  start_next.first  = cfg_data;
                CFG_SECOND_START: start_next.second = cfg_data;
                CFG_THIRD_START:  start_next.third  = cfg_data;
                default:          start_next        = start_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    assign start_pos = start_reg;

endmodule

// ===== rtl/trrc_pos.sv =====
`timescale 1ns / 1ps

module trrc_pos (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic                reload,
    input  trrc_pkg::pos_set_t  start_pos,
    output trrc_pkg::pos_set_t  cur_pos
);
    import trrc_pkg::*;

    pos_set_t pos_reg;
    pos_set_t pos_next;
    pos_set_t eff_pos;

    // Positions seen by the letter being taken: reloaded start values or the running set
    always_comb
    begin
        if (reload)
        begin
            eff_pos.first  = wrap_letter(start_pos.first);
            eff_pos.second = wrap_letter(start_pos.second);
            eff_pos.third  = wrap_letter(start_pos.third);
        end
        else
        begin
            eff_pos = pos_reg;
        end
    end

    // Advance all three rotors together after each letter
    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            pos_next.first  = step_pos(eff_pos.first);
            pos_next.second = step_pos(eff_pos.second);
            pos_next.third  = step_pos(eff_pos.third);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign cur_pos = eff_pos;

endmodule

// ===== rtl/trrc_scramble.sv =====
`timescale 1ns / 1ps

module trrc_scramble (
    input  trrc_pkg::letter_t   letter,
    input  trrc_pkg::pos_set_t  pos,
    output trrc_pkg::letter_t   result
);
    import trrc_pkg::*;

    letter_t in_wrapped;
    letter_t fwd_a;
    letter_t fwd_b;
    letter_t fwd_c;
    letter_t mirrored;
    letter_t back_c;
    letter_t back_b;

    always_comb
    begin
        in_wrapped = wrap_letter(letter);
        fwd_a      = ROTOR_A[sub_mod(in_wrapped, pos.first)];
        fwd_b      = ROTOR_B[sub_mod(fwd_a, pos.second)];
        fwd_c      = ROTOR_C[sub_mod(fwd_b, pos.third)];
        mirrored   = REFLECTOR[fwd_c];
        back_c     = add_mod(ROTOR_C_INV[mirrored], pos.third);
        back_b     = add_mod(ROTOR_B_INV[back_c], pos.second);
        result     = add_mod(ROTOR_A_INV[back_b], pos.first);
    end

endmodule
